// ----- rtl/vmag_pkg.sv -----
`timescale 1ns / 1ps

package vmag_pkg;

   // Default sizes
   localparam int MAX_ELEMENTS_DEF = 64;
   localparam int INDEX_WIDTH_DEF  = 32;

   // Field widths
   localparam int ADDR_W  = 64;
   localparam int BYTES_W = 4;
   localparam int ELEM_W  = 6;
   localparam int POS_W   = 7;
   localparam int MODE_W  = 2;
   localparam int SLOT_W  = 6;
   localparam int IVAL_W  = 32;
   localparam int MASK_W  = 64;

   localparam int REQ_DATA_W = 256;
   localparam int RSP_DATA_W = 80;

   // Request tdata layout, lowest bit first
   localparam int REQ_SLOT_LO     = 0;
   localparam int REQ_IVAL_LO     = REQ_SLOT_LO + SLOT_W;
   localparam int REQ_BASE_LO     = REQ_IVAL_LO + IVAL_W;
   localparam int REQ_STRIDE_LO   = REQ_BASE_LO + ADDR_W;
   localparam int REQ_MODE_LO     = REQ_STRIDE_LO + ADDR_W;
   localparam int REQ_BYTES_LO    = REQ_MODE_LO + MODE_W;
   localparam int REQ_UNMASKED_LO = REQ_BYTES_LO + BYTES_W;
   localparam int REQ_MASK_LO     = REQ_UNMASKED_LO + 1;
   localparam int REQ_FIRST_LO    = REQ_MASK_LO + MASK_W;
   localparam int REQ_COUNT_LO    = REQ_FIRST_LO + POS_W;
   localparam int REQ_USED_W      = REQ_COUNT_LO + POS_W;

   // Response tdata layout, lowest bit first
   localparam int RSP_ADDR_LO  = 0;
   localparam int RSP_BYTES_LO = RSP_ADDR_LO + ADDR_W;
   localparam int RSP_ELEM_LO  = RSP_BYTES_LO + BYTES_W;
   localparam int RSP_USED_W   = RSP_ELEM_LO + ELEM_W;

   // Item kinds
   localparam logic KIND_INDEX_LOAD = 1'b0;
   localparam logic KIND_INSTR      = 1'b1;

   // Addressing modes
   localparam logic [MODE_W-1:0] MODE_UNIT    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STRIDED = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INDEXED = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_BASE,
      ST_WALK
   } seq_state_type;

endpackage

// ----- rtl/vmag_index_ram.sv -----
`timescale 1ns / 1ps

module vmag_index_ram
   import vmag_pkg::*;
#(
   parameter int DEPTH = MAX_ELEMENTS_DEF,
   parameter int WIDTH = INDEX_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/vector_mem_address_generator.sv -----
`timescale 1ns / 1ps
// Channel  Dir  tdata                                           tuser  tlast
// req_     in   slot,ival,base,stride,mode,bytes,unm,mask,1st,n  kind   -
// rsp_     out  address, bytes, element index                   -      last request
//
// Index-load beat: writes one slot of the index memory.
// Instruction beat: accept, one multiply step per bit of first_element, base add,
//   then the walk from first_element up to the last active element; an instruction
//   with no active element is accepted and the sequencer stays idle. The shared
//   64-bit adder sets this walk, one element per cycle when the result register drains.
// A stalled rsp_ holds the walk on the current active element.
// req_tready is high only while the sequencer idles; reset is synchronous
//   and clears control state only; the index memory is undefined until written.

module vector_mem_address_generator
   import vmag_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
   parameter int INDEX_WIDTH  = INDEX_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // index_slot, index_value, base_address, stride, mode, access_bytes,
   // unmasked, mask_bits, first_element, element_count; zero pad to 256
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // request_address, request_bytes, element_index; zero pad to 80
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int EW        = $clog2(MAX_ELEMENTS);
   localparam int CW        = $clog2(MAX_ELEMENTS + 1);
   localparam int MUL_BIT_W = $clog2(POS_W);

   // Unpack the request beat
   logic [SLOT_W-1:0]  req_slot;
   logic [IVAL_W-1:0]  req_ival;
   logic [ADDR_W-1:0]  req_base;
   logic [ADDR_W-1:0]  req_stride;
   logic [MODE_W-1:0]  req_mode;
   logic [BYTES_W-1:0] req_bytes;
   logic               req_unmasked;
   logic [MASK_W-1:0]  req_mask;
   logic [POS_W-1:0]   req_first;
   logic [POS_W-1:0]   req_count;

   assign req_slot     = req_tdata[REQ_SLOT_LO +: SLOT_W];
   assign req_ival     = req_tdata[REQ_IVAL_LO +: IVAL_W];
   assign req_base     = req_tdata[REQ_BASE_LO +: ADDR_W];
   assign req_stride   = req_tdata[REQ_STRIDE_LO +: ADDR_W];
   assign req_mode     = req_tdata[REQ_MODE_LO +: MODE_W];
   assign req_bytes    = req_tdata[REQ_BYTES_LO +: BYTES_W];
   assign req_unmasked = req_tdata[REQ_UNMASKED_LO];
   assign req_mask     = req_tdata[REQ_MASK_LO +: MASK_W];
   assign req_first    = req_tdata[REQ_FIRST_LO +: POS_W];
   assign req_count    = req_tdata[REQ_COUNT_LO +: POS_W];

   // Sequencer state and operand registers
   seq_state_type          state_ff, state_in;
   logic [MAX_ELEMENTS-1:0] pending_ff, pending_in;
   logic [CW-1:0]          elem_ff, elem_in;
   logic [MUL_BIT_W-1:0]   mul_bit_ff, mul_bit_in;
   logic [ADDR_W-1:0]      acc_ff, acc_in;
   logic [ADDR_W-1:0]      step_ff, step_in;
   logic [ADDR_W-1:0]      base_ff, base_in;
   logic [POS_W-1:0]       first_ff, first_in;
   logic [BYTES_W-1:0]     bytes_ff, bytes_in;
   logic                   indexed_ff, indexed_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   logic [BYTES_W-1:0]     rsp_bytes_ff, rsp_bytes_in;
   logic [ELEM_W-1:0]      rsp_elem_ff, rsp_elem_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                    req_fire;
   logic [POS_W-1:0]        count_clamp;
   logic [MAX_ELEMENTS-1:0] pending_init;
   logic [EW-1:0]           elem_idx;
   logic [CW-1:0]           elem_next;
   logic [MAX_ELEMENTS-1:0] cur_onehot;
   logic [MAX_ELEMENTS-1:0] pending_rest;
   logic                    cur_active;
   logic                    out_free;
   logic                    emit;
   logic                    advance;
   logic                    walk_done;
   logic [ADDR_W-1:0]       add_a, add_b, add_sum;
   logic                    ram_wr_en;
   logic [EW-1:0]           ram_rd_addr;
   logic [INDEX_WIDTH-1:0]  ram_rd_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Clamp the vector length and build the set of elements to visit
   assign count_clamp = (req_count > POS_W'(MAX_ELEMENTS)) ? POS_W'(MAX_ELEMENTS) : req_count;

   always_comb begin
      for (int k = 0; k < MAX_ELEMENTS; k++) begin
         pending_init[k] = (POS_W'(k) >= req_first) && (POS_W'(k) < count_clamp) &&
                           (req_unmasked || req_mask[k]) &&
                           ((req_mode == MODE_UNIT) || (req_mode == MODE_STRIDED) ||
                            (req_mode == MODE_INDEXED));
      end
   end

   // Current element
   assign elem_idx  = elem_ff[EW-1:0];
   assign elem_next = elem_ff + 1'b1;

   always_comb begin
      cur_onehot           = '0;
      cur_onehot[elem_idx] = 1'b1;
   end

   assign cur_active   = pending_ff[elem_idx];
   assign pending_rest = pending_ff & ~cur_onehot;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign emit         = (state_ff == ST_WALK) && cur_active && out_free;
   assign advance      = (state_ff == ST_WALK) && (!cur_active || out_free);
   assign walk_done    = (pending_rest == '0);

   // Shared adder: multiply step, add base, walk the stride or add an index
   always_comb begin
      add_a = acc_ff;
      add_b = step_ff;
      case (state_ff)
         ST_MUL: begin
            add_a = acc_ff << 1;
            add_b = first_ff[mul_bit_ff] ? step_ff : '0;
         end
         ST_BASE: begin
            add_b = base_ff;
         end
         ST_WALK: begin
            if (indexed_ff) begin
               add_a = base_ff;
               add_b = ADDR_W'(ram_rd_data);
            end
         end
         default: begin
         end
      endcase
   end

   assign add_sum = add_a + add_b;

   // Next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      elem_in      = elem_ff;
      mul_bit_in   = mul_bit_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      base_in      = base_ff;
      first_in     = first_ff;
      bytes_in     = bytes_ff;
      indexed_in   = indexed_ff;
      ram_wr_en    = 1'b0;
      ram_rd_addr  = elem_idx;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == KIND_INDEX_LOAD) begin
                  ram_wr_en = (32'(req_slot) < MAX_ELEMENTS);
               end else if (pending_init != '0) begin
                  // Latch the instruction and start the first * step product
                  state_in   = ST_MUL;
                  pending_in = pending_init;
                  elem_in    = CW'(req_first);
                  mul_bit_in = MUL_BIT_W'(POS_W - 1);
                  acc_in     = '0;
                  step_in    = (req_mode == MODE_UNIT) ? ADDR_W'(req_bytes) : req_stride;
                  base_in    = req_base;
                  first_in   = req_first;
                  bytes_in   = req_bytes;
                  indexed_in = (req_mode == MODE_INDEXED);
               end
            end
         end
         ST_MUL: begin
            acc_in     = add_sum;
            mul_bit_in = mul_bit_ff - 1'b1;
            if (mul_bit_ff == '0) begin
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            acc_in   = add_sum;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (emit) begin
               pending_in = pending_rest;
            end
            if (advance) begin
               if (walk_done) begin
                  state_in = ST_IDLE;
               end else begin
                  elem_in     = elem_next;
                  ram_rd_addr = elem_next[EW-1:0];
                  if (!indexed_ff) begin
                     acc_in = add_sum;
                  end
               end
            end
         end
      endcase
   end

   // Load the result register, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_elem_in  = rsp_elem_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = indexed_ff ? add_sum : acc_ff;
         rsp_bytes_in = bytes_ff;
         rsp_elem_in  = ELEM_W'(elem_ff);
         rsp_last_in  = walk_done;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff      <= elem_in;
      mul_bit_ff   <= mul_bit_in;
      acc_ff       <= acc_in;
      step_ff      <= step_in;
      base_ff      <= base_in;
      first_ff     <= first_in;
      bytes_ff     <= bytes_in;
      indexed_ff   <= indexed_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_elem_ff  <= rsp_elem_in;
      rsp_last_ff  <= rsp_last_in;
   end

   vmag_index_ram #(
      .DEPTH (MAX_ELEMENTS),
      .WIDTH (INDEX_WIDTH)
   ) u_index_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (EW'(req_slot)),
      .wr_data (req_ival[INDEX_WIDTH-1:0]),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_USED_W){1'b0}}, rsp_elem_ff, rsp_bytes_ff,
                        rsp_addr_ff};

`ifndef SYNTHESIS
   // The walk always has an element left to visit
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (pending_ff != '0))
      else $error("walk entered with no pending elements");

   // A last beat ends the instruction
   assert property (@(posedge clock) disable iff (reset)
      (emit && walk_done) |=> (state_ff == ST_IDLE))
      else $error("sequencer kept walking after the last request");

   // Emitted beats never overwrite a result still waiting
   assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while stalled");

   // Multiply phase always hands over to the base add
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && mul_bit_ff == '0) |=> (state_ff == ST_BASE))
      else $error("multiply phase did not finish into base add");
`endif

endmodule
